// File: src/pvm_pkg.sv
// Package for the polyphonic wavetable voice mixer.
// Holds field widths, register codes, fixed-point constants and shared types.
// No dependencies; every other file of the block imports it.
`default_nettype none

package pvm_pkg;

    // Widths of the command and mix word fields.
    localparam int ACTION_W      = 2;
    localparam int INC_W         = 16;
    localparam int TBL_ADDR_W    = 10;
    localparam int SAMPLE_W      = 8;
    localparam int LEVEL_W       = 8;
    localparam int MIX_W         = 11;

    // Configuration register widths and codes.
    localparam int CFG_LEN_W     = 11;
    localparam int CFG_ELEN_W    = 9;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_LENGTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUSTAIN_LENGTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_LENGTH   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENVELOPE_LENGTH = 2'd3;

    localparam logic [CFG_LEN_W-1:0]  WAVE_LENGTH_RST     = 11'd1024;
    localparam logic [CFG_LEN_W-1:0]  SUSTAIN_LENGTH_RST  = 11'd512;
    localparam logic [CFG_LEN_W-1:0]  ATTACK_LENGTH_RST   = 11'd512;
    localparam logic [CFG_ELEN_W-1:0] ENVELOPE_LENGTH_RST = 9'd256;

    // Fixed-point layout of the voice state.
    localparam int PHASE_FRACTION = 8;
    localparam int ENV_FRACTION   = 7;
    localparam int PHASE_W        = CFG_LEN_W + PHASE_FRACTION;

    // Mix scaling.
    localparam int MIX_SHIFT = 8;
    localparam int MIX_CLIP  = 1016;
    localparam int PROD_W    = SAMPLE_W + LEVEL_W + 1;

    // Command codes.
    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK = 2'd0,
        ACT_NOTE = 2'd1,
        ACT_WAVE = 2'd2,
        ACT_ENV  = 2'd3
    } action_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // Live configuration.
    typedef struct packed {
        logic [CFG_LEN_W-1:0]  wave_length;
        logic [CFG_LEN_W-1:0]  sustain_length;
        logic [CFG_LEN_W-1:0]  attack_length;
        logic [CFG_ELEN_W-1:0] envelope_length;
    } cfg_t;

    // Control of one voice cell.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    // Table write request.
    typedef struct packed {
        logic                        wave_en;
        logic                        env_en;
        logic [TBL_ADDR_W-1:0]       addr;
        logic signed [SAMPLE_W-1:0]  wave;
        logic [LEVEL_W-1:0]          level;
    } tbl_wr_t;

endpackage

`default_nettype wire

// File: src/pvm_if.sv
// Handshake channels of the voice mixer: command words in, mixed samples out.
// Depends on pvm_pkg for the field widths.
`default_nettype none

interface pvm_cmd_if;
    import pvm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [INC_W-1:0]           increment;
    logic [TBL_ADDR_W-1:0]      table_index;
    logic signed [SAMPLE_W-1:0] wave_sample;
    logic [LEVEL_W-1:0]         envelope_level;

    modport source (
        output valid, action, increment, table_index, wave_sample, envelope_level,
        input  ready
    );
    modport sink (
        input  valid, action, increment, table_index, wave_sample, envelope_level,
        output ready
    );
endinterface

interface pvm_mix_if;
    import pvm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [MIX_W-1:0] mixed_sample;

    modport source (
        output valid, mixed_sample,
        input  ready
    );
    modport sink (
        input  valid, mixed_sample,
        output ready
    );
endinterface

`default_nettype wire

// File: src/polyphonic_wavetable_voice_mixer_unit.sv
// Top level of the polyphonic wavetable voice mixer: voice ring, sequencer, config.
// Depends on pvm_pkg, pvm_if, pvm_cell, pvm_voice_step and pvm_mixer.
//
//   channel  | dir | payload                                             | handshake
//   ---------+-----+-----------------------------------------------------+------------
//   cmd      | in  | action, increment, table_index, wave_sample, level  | valid/ready
//   mix      | out | mixed_sample                                        | valid/ready
//   cfg      | in  | cfg_index, cfg_data                                 | cfg_we only
//
// A note start or a table write is done in the cycle that accepts it. A sample tick rotates
// the voice ring once through the shared voice step, one voice per cycle, then drains the
// two-stage table read and multiply pipeline into the output register; the next word is
// taken in the cycle that the finished word appears. A finished word waits in the output
// register while further words are accepted; a tick that finishes while it is still held
// waits in the drain state. Reset clears the voices, the round-robin pointer, the control
// state and the sum and sets the config defaults; other data and table contents are not cleared.
`default_nettype none

module polyphonic_wavetable_voice_mixer_unit #(
    parameter int VOICES     = 32,
    parameter int WAVE_DEPTH = 1024,
    parameter int ENV_DEPTH  = 256
) (
    input  wire                              clk,
    input  wire                              rst_n,
    pvm_cmd_if.sink                          cmd,
    pvm_mix_if.source                        mix,
    input  wire                              cfg_we,
    input  wire [pvm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire [pvm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pvm_pkg::*;

    localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int WA_W  = $clog2(WAVE_DEPTH);
    localparam int EA_W  = $clog2(ENV_DEPTH);
    localparam int POS_W = EA_W + ENV_FRACTION;

    state_t             state_reg, state_next;
    logic [VW-1:0]      cnt_reg, cnt_next;
    logic [VW-1:0]      next_voice_reg, next_voice_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [MIX_W-1:0] out_sample_reg, out_sample_next;
    cfg_t               cfg_reg, cfg_next;

    action_t            action;
    logic               accept;
    logic               tick_go;
    logic               note_go;
    logic               shift;
    logic               issue;
    logic               out_load;
    logic               last_voice;
    logic               busy;
    logic               out_free;
    tbl_wr_t            wr;
    logic signed [MIX_W-1:0] mix_value;

    logic [INC_W-1:0]   cell_inc   [VOICES];
    logic [PHASE_W-1:0] cell_phase [VOICES];
    logic [POS_W-1:0]   cell_pos   [VOICES];
    logic [PHASE_W-1:0] step_phase;
    logic [POS_W-1:0]   step_pos;
    logic [WA_W-1:0]    widx;
    logic [EA_W-1:0]    eidx;

    assign action  = action_t'(cmd.action);
    assign accept  = cmd.valid && cmd.ready;
    assign tick_go = accept && (action == ACT_TICK);
    assign note_go = accept && (action == ACT_NOTE);

    // Table write requests straight from the command word.
    assign wr.wave_en = accept && (action == ACT_WAVE);
    assign wr.env_en  = accept && (action == ACT_ENV);
    assign wr.addr    = cmd.table_index;
    assign wr.wave    = cmd.wave_sample;
    assign wr.level   = cmd.envelope_level;

    // Voice ring: each cell takes its upper neighbor's voice, the top cell the stepped head.
    for (genvar i = 0; i < VOICES; i++)
    begin : g_cell
        cell_ctrl_t ctrl;
        logic [INC_W-1:0]   in_inc;
        logic [PHASE_W-1:0] in_phase;
        logic [POS_W-1:0]   in_pos;

        assign ctrl.shift = shift;
        assign ctrl.load  = note_go && (next_voice_reg == VW'(i));

        if (i == VOICES - 1)
        begin : g_tail
            assign in_inc   = cell_inc[0];
            assign in_phase = step_phase;
            assign in_pos   = step_pos;
        end
        else
        begin : g_body
            assign in_inc   = cell_inc[i+1];
            assign in_phase = cell_phase[i+1];
            assign in_pos   = cell_pos[i+1];
        end

        pvm_cell #(
            .POS_W (POS_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .load_inc    (cmd.increment),
            .shift_inc   (in_inc),
            .shift_phase (in_phase),
            .shift_pos   (in_pos),
            .inc         (cell_inc[i]),
            .phase       (cell_phase[i]),
            .pos         (cell_pos[i])
        );
    end

    // Shared step for the voice at the head of the ring.
    pvm_voice_step #(
        .WAVE_DEPTH (WAVE_DEPTH),
        .ENV_DEPTH  (ENV_DEPTH)
    ) u_step (
        .cfg        (cfg_reg),
        .inc        (cell_inc[0]),
        .phase      (cell_phase[0]),
        .pos        (cell_pos[0]),
        .phase_next (step_phase),
        .pos_next   (step_pos),
        .widx       (widx),
        .eidx       (eidx)
    );

    pvm_mixer #(
        .VOICES     (VOICES),
        .WAVE_DEPTH (WAVE_DEPTH),
        .ENV_DEPTH  (ENV_DEPTH)
    ) u_mixer (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .clear     (tick_go),
        .widx      (widx),
        .eidx      (eidx),
        .wr        (wr),
        .busy      (busy),
        .mix_value (mix_value)
    );

    assign last_voice = (cnt_reg == VW'(VOICES - 1));
    assign out_free   = !out_valid_reg || mix.ready;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_go)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_voice)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!busy && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        cmd.ready = 1'b0;
        shift     = 1'b0;
        issue     = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            ST_RUN:
            begin
                shift = 1'b1;
                issue = 1'b1;
            end
            ST_DRAIN:
            begin
                out_load = !busy && out_free;
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    // Voice counter, round-robin pointer and output word.
    always_comb
    begin
        cnt_next        = shift ? (last_voice ? '0 : cnt_reg + VW'(1)) : cnt_reg;
        next_voice_next = next_voice_reg;
        if (note_go)
        begin
            next_voice_next = (next_voice_reg == VW'(VOICES - 1)) ? '0
                                                                  : next_voice_reg + VW'(1);
        end
        out_sample_next = out_load ? mix_value : out_sample_reg;
        out_valid_next  = out_load ? 1'b1 : (mix.ready ? 1'b0 : out_valid_reg);
    end

    // Configuration writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WAVE_LENGTH:     cfg_next.wave_length     = cfg_data[CFG_LEN_W-1:0];
                CFG_SUSTAIN_LENGTH:  cfg_next.sustain_length  = cfg_data[CFG_LEN_W-1:0];
                CFG_ATTACK_LENGTH:   cfg_next.attack_length   = cfg_data[CFG_LEN_W-1:0];
                CFG_ENVELOPE_LENGTH: cfg_next.envelope_length = cfg_data[CFG_ELEN_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                   <= ST_IDLE;
            cnt_reg                     <= '0;
            next_voice_reg              <= '0;
            out_valid_reg               <= 1'b0;
            cfg_reg.wave_length         <= WAVE_LENGTH_RST;
            cfg_reg.sustain_length      <= SUSTAIN_LENGTH_RST;
            cfg_reg.attack_length       <= ATTACK_LENGTH_RST;
            cfg_reg.envelope_length     <= ENVELOPE_LENGTH_RST;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            next_voice_reg <= next_voice_next;
            out_valid_reg  <= out_valid_next;
            cfg_reg        <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sample_reg <= out_sample_next;
    end

    assign mix.valid        = out_valid_reg;
    assign mix.mixed_sample = out_sample_reg;

endmodule

`default_nettype wire

// File: src/pvm_cell.sv
// One voice cell of the rotating voice ring: increment, phase and envelope position.
// Depends on pvm_pkg.
`default_nettype none

module pvm_cell #(
    parameter int POS_W = 15
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  pvm_pkg::cell_ctrl_t         ctrl,
    input  wire [pvm_pkg::INC_W-1:0]    load_inc,
    input  wire [pvm_pkg::INC_W-1:0]    shift_inc,
    input  wire [pvm_pkg::PHASE_W-1:0]  shift_phase,
    input  wire [POS_W-1:0]             shift_pos,
    output logic [pvm_pkg::INC_W-1:0]   inc,
    output logic [pvm_pkg::PHASE_W-1:0] phase,
    output logic [POS_W-1:0]            pos
);
    import pvm_pkg::*;

    logic [INC_W-1:0]   inc_reg, inc_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    // A note start restarts the voice; otherwise take the neighbor's voice on a shift,
    // and hold the voice when neither happens.
    always_comb
    begin
        priority if (ctrl.load)
        begin
            inc_next   = load_inc;
            phase_next = '0;
            pos_next   = '0;
        end
        else if (ctrl.shift)
        begin
            inc_next   = shift_inc;
            phase_next = shift_phase;
            pos_next   = shift_pos;
        end
        else
        begin
            inc_next   = inc_reg;
            phase_next = phase_reg;
            pos_next   = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_reg   <= '0;
            phase_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            inc_reg   <= inc_next;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

    assign inc   = inc_reg;
    assign phase = phase_reg;
    assign pos   = pos_reg;

endmodule

`default_nettype wire

// File: src/pvm_voice_step.sv
// Advance of the voice at the head of the ring: phase loop, envelope step, table addresses.
// Depends on pvm_pkg.
`default_nettype none

module pvm_voice_step #(
    parameter int WAVE_DEPTH = 1024,
    parameter int ENV_DEPTH  = 256,
    localparam int WA_W  = $clog2(WAVE_DEPTH),
    localparam int EA_W  = $clog2(ENV_DEPTH),
    localparam int POS_W = EA_W + pvm_pkg::ENV_FRACTION
) (
    input  pvm_pkg::cfg_t                cfg,
    input  wire [pvm_pkg::INC_W-1:0]     inc,
    input  wire [pvm_pkg::PHASE_W-1:0]   phase,
    input  wire [POS_W-1:0]              pos,
    output logic [pvm_pkg::PHASE_W-1:0]  phase_next,
    output logic [POS_W-1:0]             pos_next,
    output logic [WA_W-1:0]              widx,
    output logic [EA_W-1:0]              eidx
);
    import pvm_pkg::*;

    localparam int ELEN_W = (EA_W + 1 > CFG_ELEN_W) ? EA_W + 1 : CFG_ELEN_W;
    localparam int LIM_W  = ELEN_W + ENV_FRACTION;
    localparam int IDX_W  = PHASE_W - PHASE_FRACTION;

    logic [PHASE_W:0]        raw_sum;
    logic [PHASE_W-1:0]      ph_wrap;
    logic [PHASE_W-1:0]      end_mark;
    logic [PHASE_W-1:0]      loop_len;
    logic [PHASE_W-1:0]      attack_mark;
    logic [IDX_W+WA_W-1:0]   widx_ext;
    logic [ELEN_W-1:0]       env_len_ext;
    logic [ELEN_W-1:0]       depth_ext;
    logic [ELEN_W-1:0]       elen;
    logic [LIM_W-1:0]        elimit;
    logic [LIM_W:0]          pos_plus;
    logic                    advance;

    // Phase accumulate, wrapping at the accumulator width.
    assign raw_sum = {1'b0, phase} + (PHASE_W + 1)'(inc);
    assign ph_wrap = raw_sum[PHASE_W-1:0];

    // Past the waveform end the phase jumps back by the sustain loop.
    assign end_mark    = {cfg.wave_length, {PHASE_FRACTION{1'b0}}};
    assign loop_len    = {cfg.sustain_length, {PHASE_FRACTION{1'b0}}};
    assign attack_mark = {cfg.attack_length, {PHASE_FRACTION{1'b0}}};
    assign phase_next  = (ph_wrap >= end_mark) ? ph_wrap - loop_len : ph_wrap;

    // Waveform index wraps modulo the table depth.
    assign widx_ext = {{WA_W{1'b0}}, phase_next[PHASE_W-1:PHASE_FRACTION]};
    assign widx     = widx_ext[WA_W-1:0];

    // Envelope length is capped at the table depth.
    assign env_len_ext = ELEN_W'(cfg.envelope_length);
    assign depth_ext   = ELEN_W'(ENV_DEPTH);
    assign elen        = (env_len_ext > depth_ext) ? depth_ext : env_len_ext;
    assign elimit      = {elen, {ENV_FRACTION{1'b0}}};

    // The envelope steps once past the attack region, stopping at its last entry.
    assign pos_plus = (LIM_W + 1)'(pos) + (LIM_W + 1)'(1);
    assign advance  = (phase_next >= attack_mark) && (pos_plus < {1'b0, elimit});
    assign pos_next = advance ? pos + POS_W'(1) : pos;

    // Envelope read uses the position from before the step.
    assign eidx = pos[POS_W-1:ENV_FRACTION];

endmodule

`default_nettype wire

// File: src/pvm_mixer.sv
// Wave and envelope tables, weighting multiplier, mix accumulator and output clip.
// Depends on pvm_pkg.
`default_nettype none

module pvm_mixer #(
    parameter int VOICES     = 32,
    parameter int WAVE_DEPTH = 1024,
    parameter int ENV_DEPTH  = 256,
    localparam int WA_W = $clog2(WAVE_DEPTH),
    localparam int EA_W = $clog2(ENV_DEPTH)
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               issue,
    input  wire                               clear,
    input  wire [WA_W-1:0]                    widx,
    input  wire [EA_W-1:0]                    eidx,
    input  pvm_pkg::tbl_wr_t                  wr,
    output logic                              busy,
    output logic signed [pvm_pkg::MIX_W-1:0]  mix_value
);
    import pvm_pkg::*;

    localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SUM_W = PROD_W + VW + 1;
    localparam logic signed [SUM_W-1:0] CLIP_HI = SUM_W'(MIX_CLIP);
    localparam logic signed [SUM_W-1:0] CLIP_LO = -CLIP_HI;

    logic signed [SAMPLE_W-1:0] wave_mem [WAVE_DEPTH];
    logic [LEVEL_W-1:0]         env_mem  [ENV_DEPTH];

    logic [TBL_ADDR_W+WA_W-1:0] wave_addr_ext;
    logic [TBL_ADDR_W+EA_W-1:0] env_addr_ext;
    logic [WA_W-1:0]            wave_addr;
    logic [EA_W-1:0]            env_addr;
    logic                       wave_we;
    logic                       env_we;

    logic signed [SAMPLE_W-1:0] wave_q_reg;
    logic [LEVEL_W-1:0]         env_q_reg;
    logic signed [LEVEL_W:0]    env_s;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [SUM_W-1:0]    acc_reg, acc_next;
    logic signed [SUM_W-1:0]    shifted;
    logic                       s1_valid_reg, s2_valid_reg;

    // Table writes; addresses beyond a table are dropped.
    assign wave_addr_ext = {{WA_W{1'b0}}, wr.addr};
    assign env_addr_ext  = {{EA_W{1'b0}}, wr.addr};
    assign wave_addr     = wave_addr_ext[WA_W-1:0];
    assign env_addr      = env_addr_ext[EA_W-1:0];
    assign wave_we       = wr.wave_en && (32'(wr.addr) < 32'(WAVE_DEPTH));
    assign env_we        = wr.env_en && (32'(wr.addr) < 32'(ENV_DEPTH));

    // Waveform table with registered read.
    always_ff @(posedge clk)
    begin
        if (wave_we)
        begin
            wave_mem[wave_addr] <= wr.wave;
        end
        wave_q_reg <= wave_mem[widx];
    end

    // Envelope table with registered read.
    always_ff @(posedge clk)
    begin
        if (env_we)
        begin
            env_mem[env_addr] <= wr.level;
        end
        env_q_reg <= env_mem[eidx];
    end

    // Weighting product and running sum.
    assign env_s     = {1'b0, env_q_reg};
    assign prod_next = wave_q_reg * env_s;
    assign acc_next  = clear ? '0 : (s2_valid_reg ? acc_reg + SUM_W'(prod_reg) : acc_reg);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            acc_reg      <= acc_next;
        end
    end

    assign busy = s1_valid_reg || s2_valid_reg;

    // Floor shift of the sum, then clip to plus or minus MIX_CLIP.
    assign shifted = acc_reg >>> MIX_SHIFT;

    always_comb
    begin
        priority if (shifted > CLIP_HI)
        begin
            mix_value = CLIP_HI[MIX_W-1:0];
        end
        else if (shifted < CLIP_LO)
        begin
            mix_value = CLIP_LO[MIX_W-1:0];
        end
        else
        begin
            mix_value = shifted[MIX_W-1:0];
        end
    end

endmodule

`default_nettype wire
